// ----- rtl/ordered_list_with_positional_insert_defines.svh -----
// Assertion macros shared by the ordered list RTL.
`ifndef ORDERED_LIST_WITH_POSITIONAL_INSERT_DEFINES_SVH
`define ORDERED_LIST_WITH_POSITIONAL_INSERT_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define OLPI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olpi check failed in the same cycle");

// The condition holds in the cycle after the trigger.
`define OLPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olpi check failed one cycle later");

`endif

// ----- rtl/olpi_pkg.sv -----
// Types and constants for the ordered list with positional insert.
`timescale 1ns / 1ps
package olpi_pkg;

  localparam int DATA_W    = 32;
  localparam int MODE_W    = 3;
  localparam int IDX_W     = 5;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_INSERT_AT  = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // What every cell of the chain does in each cycle.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_INSERT     = 2'd1,
    CELL_SHIFT_DOWN = 2'd2
  } cell_op_t;

endpackage

// ----- rtl/olpi_cell.sv -----
// One storage cell of the list chain: holds one entry and moves it to a neighbor.
`timescale 1ns / 1ps
module olpi_cell import olpi_pkg::*; #(
  parameter int CW       = 5,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [CW-1:0]     pos,
  input  logic [CW-1:0]     count,
  input  logic [DATA_W-1:0] new_val,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] val,
  output logic [DATA_W-1:0] tail_val
);

  localparam logic [CW-1:0] MY_IDX  = CW'(CELL_IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(CELL_IDX + 1);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (op)
      CELL_HOLD: begin
        val_nxt = val_r;
      end
      CELL_INSERT: begin
        // take the new item at the slot, open the gap above it
        if (MY_IDX == pos) begin
          val_nxt = new_val;
        end else if ((MY_IDX > pos) && (MY_IDX <= count)) begin
          val_nxt = left_val;
        end
      end
      CELL_SHIFT_DOWN: begin
        val_nxt = right_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val      = val_r;
  // offer the entry to the back-removal OR tree only when this is the last one
  assign tail_val = (MY_NEXT == count) ? val_r : '0;

endmodule

// ----- rtl/ordered_list_with_positional_insert.sv -----
// Top level of the ordered list with positional insert: a chain of entry cells.
//
// Usage:
//   Drive a command on in_mode / in_item_value / in_insert_index and raise
//   start; the command is accepted at a rising edge where start is high and
//   busy is low. busy stays low: every cell updates its entry in the same
//   cycle, so one command is taken every clock cycle.
//   Commands: push front, push back, insert at index (clamped to the count),
//   pop front, pop back. Unused mode codes change nothing and report done.
//   Each accepted command yields exactly one result in the next cycle:
//   out_valid is high for that single cycle with out_status, out_removed_value
//   and out_item_count (count after the command). The receiver cannot stall;
//   the result must be taken in that cycle.
//   The result comes from the result register; throughput is one item
//   per cycle, set by the cell chain where each cell picks its own neighbor.
//   Inserting into a full list reports full, popping an empty one reports
//   empty; in both cases the list is left as it was.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; entry contents are not cleared and are never read before written.
`timescale 1ns / 1ps
`include "ordered_list_with_positional_insert_defines.svh"
module ordered_list_with_positional_insert import olpi_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic [IDX_W-1:0]         in_insert_index,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic [CNT_OUT_W-1:0]     out_item_count
);

  // count width holds CAPACITY itself; index compare width covers both sides
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic              accept;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              list_full;
  logic              list_empty;
  logic              count_step_ok;

  cell_op_t          cell_op;
  logic [CW-1:0]     cell_pos;
  logic [DATA_W-1:0] cell_val  [CAPACITY];
  logic [DATA_W-1:0] cell_tail [CAPACITY];
  logic [DATA_W-1:0] tail_val;

  status_t           status_nxt;
  logic [DATA_W-1:0] removed_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_removed_r;
  logic [CW-1:0]     out_count_r;

  // every cell updates at the edge that takes the command, so the block never refuses one
  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign list_full  = (count_r == CAP_C);
  assign list_empty = (count_r == '0);

  // Gather the last live entry: at most one cell drives a nonzero tail value.
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_val = tail_val | cell_tail[i];
    end
  end

  // Command decoder: pick the chain operation, the new count and the result.
  always_comb begin
    cell_op     = CELL_HOLD;
    cell_pos    = count_r;
    count_nxt   = count_r;
    status_nxt  = STATUS_DONE;
    removed_nxt = '0;
    if (accept) begin
      unique case (in_mode) inside
        MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT: begin
          if (list_full) begin
            status_nxt = STATUS_FULL;
          end else begin
            cell_op   = CELL_INSERT;
            count_nxt = count_r + 1'b1;
            if (in_mode == MODE_PUSH_FRONT) begin
              cell_pos = '0;
            end else if (in_mode == MODE_PUSH_BACK) begin
              cell_pos = count_r;
            end else if (IW'(in_insert_index) > IW'(count_r)) begin
              // clamp an index past the end to the back
              cell_pos = count_r;
            end else begin
              cell_pos = CW'(in_insert_index);
            end
          end
        end
        MODE_POP_FRONT: begin
          if (list_empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            cell_op     = CELL_SHIFT_DOWN;
            removed_nxt = cell_val[0];
            count_nxt   = count_r - 1'b1;
          end
        end
        MODE_POP_BACK: begin
          if (list_empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            // entries above the new count are simply dropped
            removed_nxt = tail_val;
            count_nxt   = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = STATUS_DONE;
        end
      endcase
    end
  end

  // Chain of cells; cell 0 is the front of the list.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_val;
    logic [DATA_W-1:0] right_val;

    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_left
      assign left_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner_right
      assign right_val = cell_val[g+1];
    end

    olpi_cell #(
      .CW       (CW),
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .pos       (cell_pos),
      .count     (count_r),
      .new_val   (in_item_value),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[g]),
      .tail_val  (cell_tail[g])
    );
  end

  // Count and result strobe are control state; clear them at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Result payload: hold it for the strobe cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status_nxt;
      out_removed_r <= removed_nxt;
      out_count_r   <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_item_count    = CNT_OUT_W'(out_count_r);

  // a command moves the count by at most one
  assign count_step_ok = (count_nxt == count_r) ||
                         (count_nxt == CW'(count_r + 1'b1)) ||
                         (count_nxt == CW'(count_r - 1'b1));

  `OLPI_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CAP_C)
  `OLPI_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, out_valid)
  `OLPI_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !accept, !out_valid)
  `OLPI_ASSERT_SAME(a_full_means_full, clk, rst_n, out_valid && out_status_r == STATUS_FULL, list_full)
  `OLPI_ASSERT_SAME(a_count_step, clk, rst_n, 1'b1, count_step_ok)

endmodule

// ----- test/ordered_list_with_positional_insert_tb.sv -----
// Self-checking bench for the ordered list: directed table, then paced random command bursts.
`timescale 1ns / 1ps
module ordered_list_with_positional_insert_tb;
  import olpi_pkg::*;

  localparam int LIST_CAPACITY = 16;
  localparam int RANDOM_ITEMS  = 820;
  localparam int DIRECTED_ROWS = 21;
  // Mode codes the block leaves unused; they must change nothing.
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  // One result as the block reports it.
  typedef struct packed {
    status_t                     status;
    logic signed [DATA_W-1:0]    removed;
    logic [CNT_OUT_W-1:0]        count;
  } outcome_t;

  // One row of the directed table. A row with reps > 1 is issued that many
  // times, the value stepping by one each time. Pinned rows carry a result
  // typed in by hand; the rest are checked against the list predictor.
  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    int                       reps;
    bit                       pinned;
    outcome_t                 result;
  } cmd_row_t;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_style_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [MODE_W-1:0]        in_mode = '0;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic [IDX_W-1:0]         in_insert_index = '0;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_removed_value;
  logic [CNT_OUT_W-1:0]     out_item_count;

  // Hand-typed result that travels with the command on the same edge.
  bit       pin_valid = 1'b0;
  outcome_t pin_result = '0;

  // Predictor state: the list as it should be, front at index 0.
  logic signed [DATA_W-1:0] held_items[$];
  outcome_t                 pending_results[$];
  outcome_t                 predicted;
  outcome_t                 oldest;

  int  mismatch_count = 0;
  int  accepted_count = 0;
  int  full_rejects = 0;
  int  empty_rejects = 0;
  int  peak_depth = 0;

  cmd_row_t directed_rows [DIRECTED_ROWS];

  ordered_list_with_positional_insert #(
    .CAPACITY(LIST_CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_item_value(in_item_value),
    .in_insert_index(in_insert_index),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_removed_value(out_removed_value),
    .out_item_count(out_item_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the predicted list and return what the block owes.
  function automatic outcome_t apply_to_list(input logic [MODE_W-1:0] mode,
                                             input logic signed [DATA_W-1:0] value,
                                             input logic [IDX_W-1:0] index);
    outcome_t res;
    int       pos;
    res.status  = STATUS_DONE;
    res.removed = '0;
    case (mode) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT: begin
        if (held_items.size() >= LIST_CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          if (mode == MODE_PUSH_FRONT) pos = 0;
          else if (mode == MODE_PUSH_BACK) pos = held_items.size();
          // Clamp the index to the count: past the end means the back.
          else pos = (int'(index) > held_items.size()) ? held_items.size() : int'(index);
          held_items.insert(pos, value);
        end
      end
      MODE_POP_FRONT: begin
        if (held_items.size() == 0) res.status = STATUS_EMPTY;
        else res.removed = held_items.pop_front();
      end
      MODE_POP_BACK: begin
        if (held_items.size() == 0) res.status = STATUS_EMPTY;
        else res.removed = held_items.pop_back();
      end
      default: ;  // spare codes leave the list alone
    endcase
    res.count = CNT_OUT_W'(held_items.size());
    return res;
  endfunction

  // Sample everything at the rising edge, where all values are the settled
  // ones from the previous cycle. Check the result first: as it is registered,
  // it belongs to an item accepted at an earlier edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d removed %0d count %0d",
                   $time, out_status, out_removed_value, out_item_count);
          mismatch_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_status !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time, oldest.status, out_status);
            mismatch_count++;
          end
          if (out_removed_value !== oldest.removed) begin
            $display("%0t: removed value expected %0d actual %0d",
                     $time, oldest.removed, out_removed_value);
            mismatch_count++;
          end
          if (out_item_count !== oldest.count) begin
            $display("%0t: item count expected %0d actual %0d",
                     $time, oldest.count, out_item_count);
            mismatch_count++;
          end
        end
        if (out_status == STATUS_FULL) full_rejects++;
        if (out_status == STATUS_EMPTY) empty_rejects++;
      end
      if (start && !busy) begin
        predicted = apply_to_list(in_mode, in_item_value, in_insert_index);
        // A pinned row overrides the prediction; the list still advances.
        if (pin_valid) predicted = pin_result;
        pending_results.push_back(predicted);
        accepted_count++;
        if (held_items.size() > peak_depth) peak_depth = held_items.size();
      end
    end
  end

  // Drive one command and hold it until the block takes it.
  task automatic issue_command(input logic [MODE_W-1:0] mode,
                               input logic signed [DATA_W-1:0] value,
                               input logic [IDX_W-1:0] index,
                               input bit pinned,
                               input outcome_t pinned_result);
    start           <= 1'b1;
    in_mode         <= mode;
    in_item_value   <= value;
    in_insert_index <= index;
    pin_valid       <= pinned;
    pin_result      <= pinned_result;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for the given number of cycles.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int                       sent;
    int                       phase;
    int                       idle_pct;
    int                       insert_pct;
    int                       burst_len;
    int                       wait_cycles;
    burst_style_t             style;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;

    // Directed table. Pinned results are the ones obvious by inspection:
    // the empty list after reset, the first two inserts, and a full list.
    directed_rows = '{
      '{MODE_POP_FRONT,   32'sd0,            5'd0,  1, 1'b1, '{STATUS_EMPTY, 32'sd0, 5'd0}},
      '{MODE_POP_BACK,    32'sd0,            5'd0,  1, 1'b1, '{STATUS_EMPTY, 32'sd0, 5'd0}},
      '{MODE_SPARE_FIRST, 32'sd0,            5'd0,  1, 1'b1, '{STATUS_DONE,  32'sd0, 5'd0}},
      '{MODE_PUSH_BACK,   32'sh7fffffff,     5'd0,  1, 1'b1, '{STATUS_DONE,  32'sd0, 5'd1}},
      '{MODE_PUSH_FRONT,  32'sh80000000,     5'd0,  1, 1'b1, '{STATUS_DONE,  32'sd0, 5'd2}},
      '{MODE_INSERT_AT,   -32'sd1,           5'd1,  1, 1'b0, '0},
      '{MODE_INSERT_AT,   32'sd0,            5'd31, 1, 1'b0, '0},
      '{MODE_INSERT_AT,   32'sh55555555,     5'd16, 1, 1'b0, '0},
      '{MODE_INSERT_AT,   32'shaaaaaaaa,     5'd0,  1, 1'b0, '0},
      '{MODE_POP_FRONT,   32'sd0,            5'd0,  1, 1'b0, '0},
      '{MODE_POP_BACK,    32'sd0,            5'd0,  1, 1'b0, '0},
      '{MODE_SPARE_FIRST + 3'd1, 32'sd9,     5'd7,  1, 1'b0, '0},
      '{MODE_PUSH_BACK,   32'sd100,          5'd0, 10, 1'b0, '0},
      '{MODE_INSERT_AT,   32'sd12345,        5'd15, 1, 1'b0, '0},
      '{MODE_INSERT_AT,   -32'sd7,           5'd2,  1, 1'b0, '0},
      '{MODE_PUSH_FRONT,  32'sd1,            5'd0,  1, 1'b1, '{STATUS_FULL,  32'sd0, 5'd16}},
      '{MODE_PUSH_BACK,   32'sd2,            5'd0,  1, 1'b1, '{STATUS_FULL,  32'sd0, 5'd16}},
      '{MODE_INSERT_AT,   32'sd3,            5'd3,  1, 1'b1, '{STATUS_FULL,  32'sd0, 5'd16}},
      '{MODE_SPARE_LAST,  32'sd4,            5'd31, 1, 1'b1, '{STATUS_DONE,  32'sd0, 5'd16}},
      '{MODE_POP_BACK,    32'sd0,            5'd0,  1, 1'b0, '0},
      '{MODE_POP_FRONT,   32'sd0,            5'd0,  1, 1'b0, '0}
    };

    // Hold reset low first, then release it for good.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        issue_command(directed_rows[r].mode, directed_rows[r].value + k,
                      directed_rows[r].index, directed_rows[r].pinned,
                      directed_rows[r].result);
      end
    end

    // Random part in bursts that lean toward filling, draining or neither,
    // so the list keeps crossing between empty and full. Pacing changes
    // across four quarters: back to back, sender idle often, back to back
    // again (the result side cannot stall, so its phase adds no gaps), and
    // sender idle now and then.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      style     = burst_style_t'($urandom_range(BURST_FILL, BURST_MIXED));
      burst_len = $urandom_range(4, 40);
      case (style)
        BURST_FILL:  insert_pct = 80;
        BURST_DRAIN: insert_pct = 20;
        default:     insert_pct = 50;
      endcase
      for (int b = 0; (b < burst_len) && (sent < RANDOM_ITEMS); b++) begin
        phase = sent * 4 / RANDOM_ITEMS;
        case (phase)
          1:       idle_pct = 65;
          3:       idle_pct = 22;
          default: idle_pct = 0;
        endcase
        // Draw anew before each idle cycle, so idle_pct is the share of idle cycles.
        while ($urandom_range(1, 100) <= idle_pct) hold_off(1);

        if ($urandom_range(0, 99) < 3)
          mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        else if ($urandom_range(0, 99) < insert_pct)
          mode = MODE_W'($urandom_range(MODE_PUSH_FRONT, MODE_INSERT_AT));
        else
          mode = MODE_W'($urandom_range(MODE_POP_FRONT, MODE_POP_BACK));

        // Mostly random payloads, with the extremes mixed in.
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       value = 32'sh7fffffff;
            1:       value = 32'sh80000000;
            2:       value = 32'sd0;
            default: value = -32'sd1;
          endcase
        end else begin
          value = $urandom;
        end

        // Keep most indexes within the list's range; the rest exercise clamping.
        if ($urandom_range(0, 3) == 0) index = IDX_W'($urandom_range(0, 31));
        else index = IDX_W'($urandom_range(0, LIST_CAPACITY));

        issue_command(mode, value, index, 1'b0, '0);
        sent++;
      end
    end
    start <= 1'b0;

    // Let the last results drain, then wait on for stray strobes.
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 50) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatch_count++;
    end

    $display("Covered %0d commands in four pacing phases, list depth up to %0d.",
             accepted_count, peak_depth);
    $display("Inserts turned away when full: %0d; removals from an empty list: %0d.",
             full_rejects, empty_rejects);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under 10 us.
  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
